// File: src/complex_arithmetic_unit_defines.svh
// Assertion helpers for the block that checks itself.
// Both expect i_clk and i_rst_n in scope.
`ifndef COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CAU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cau: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define CAU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cau: next-cycle check failed");

`endif

// File: src/cau_pkg.sv
package cau_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int OP_BITS   = 3;

    // exact products, their sums, |b|^2, divisor 2|b|^2 and the scaled dividend
    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = 2 * WORD_BITS + 1;
    localparam int DEN_BITS  = 2 * WORD_BITS;
    localparam int DVS_BITS  = DEN_BITS + 1;
    localparam int NUM_BITS  = SUM_BITS + FRAC_BITS + 1;

    localparam longint ROUND_HALF = (longint'(1) << FRAC_BITS) >> 1;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_NEG = 3'd4
    } t_op;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [WORD_BITS:0]   t_lin;
    typedef logic signed [PROD_BITS-1:0] t_prod;
    typedef logic signed [SUM_BITS-1:0]  t_sw;
    typedef logic [NUM_BITS-1:0]         t_num;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    // exact sums after the multiplier stage
    typedef struct packed {
        logic [OP_BITS-1:0]  op;
        logic signed [SUM_BITS-1:0] sr;
        logic signed [SUM_BITS-1:0] si;
        logic [DEN_BITS-1:0] den;
    } t_sum;

    // one result part in sign-magnitude, with divider state
    typedef struct packed {
        logic                 neg;
        logic                 big;
        logic                 div;
        logic [DVS_BITS-1:0]  rem;
        logic [WORD_BITS-1:0] num;
        logic [WORD_BITS-1:0] q;
    } t_lane;

    typedef struct packed {
        t_lane               re;
        t_lane               im;
        logic [DVS_BITS-1:0] dvs;
        logic                dz;
    } t_item;

endpackage

// File: src/cau_in_if.sv
interface cau_in_if;
    import cau_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_BITS-1:0] operation;
    t_word              a_real;
    t_word              a_imag;
    t_word              b_real;
    t_word              b_imag;

    modport source (output valid, operation, a_real, a_imag, b_real, b_imag, input ready);
    modport sink   (input valid, operation, a_real, a_imag, b_real, b_imag, output ready);
endinterface

// File: src/cau_out_if.sv
interface cau_out_if;
    import cau_pkg::*;

    logic  valid;
    logic  ready;
    t_word result_real;
    t_word result_imag;
    logic  divide_by_zero;
    logic  overflow;

    modport source (output valid, result_real, result_imag, divide_by_zero, overflow,
                    input ready);
    modport sink   (input valid, result_real, result_imag, divide_by_zero, overflow,
                    output ready);
endinterface

// File: src/cau_front.sv
module cau_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  logic [cau_pkg::OP_BITS-1:0] i_op,
    input  cau_pkg::t_word            i_a_real,
    input  cau_pkg::t_word            i_a_imag,
    input  cau_pkg::t_word            i_b_real,
    input  cau_pkg::t_word            i_b_imag,
    output logic                      o_valid,
    output cau_pkg::t_sum             o_sum
);
    import cau_pkg::*;

    logic               r_v1;
    logic [OP_BITS-1:0] r_op1;
    t_lin               r_lin_r, r_lin_i;
    t_prod              r_p_rr, r_p_ii, r_p_ri, r_p_ir, r_p_bbr, r_p_bbi;
    t_lin               n_lin_r, n_lin_i;
    t_sum               n_sum, r_sum;
    logic               r_v2;

    // linear ops need no multiplier; settle them in the first stage
    always_comb begin
        case (t_op'(i_op))
            OP_ADD: begin
                n_lin_r = t_lin'(i_a_real) + t_lin'(i_b_real);
                n_lin_i = t_lin'(i_a_imag) + t_lin'(i_b_imag);
            end
            OP_SUB: begin
                n_lin_r = t_lin'(i_a_real) - t_lin'(i_b_real);
                n_lin_i = t_lin'(i_a_imag) - t_lin'(i_b_imag);
            end
            OP_NEG: begin
                n_lin_r = -t_lin'(i_a_real);
                n_lin_i = -t_lin'(i_a_imag);
            end
            default: begin
                n_lin_r = '0;
                n_lin_i = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op1   <= i_op;
            r_lin_r <= n_lin_r;
            r_lin_i <= n_lin_i;
            r_p_rr  <= t_prod'(i_a_real) * t_prod'(i_b_real);
            r_p_ii  <= t_prod'(i_a_imag) * t_prod'(i_b_imag);
            r_p_ri  <= t_prod'(i_a_real) * t_prod'(i_b_imag);
            r_p_ir  <= t_prod'(i_a_imag) * t_prod'(i_b_real);
            r_p_bbr <= t_prod'(i_b_real) * t_prod'(i_b_real);
            r_p_bbi <= t_prod'(i_b_imag) * t_prod'(i_b_imag);
            r_sum   <= n_sum;
        end
    end

    always_comb begin
        n_sum     = '0;
        n_sum.op  = r_op1;
        n_sum.den = DEN_BITS'(r_p_bbr) + DEN_BITS'(r_p_bbi);
        case (t_op'(r_op1))
            OP_ADD, OP_SUB, OP_NEG: begin
                n_sum.sr = t_sw'(r_lin_r);
                n_sum.si = t_sw'(r_lin_i);
            end
            OP_MUL: begin
                n_sum.sr = t_sw'(r_p_rr) - t_sw'(r_p_ii);
                n_sum.si = t_sw'(r_p_ri) + t_sw'(r_p_ir);
            end
            OP_DIV: begin
                n_sum.sr = t_sw'(r_p_rr) + t_sw'(r_p_ii);
                n_sum.si = t_sw'(r_p_ir) - t_sw'(r_p_ri);
            end
            default: begin
                n_sum.sr = '0;
                n_sum.si = '0;
            end
        endcase
    end

    assign o_valid = r_v2;
    assign o_sum   = r_sum;
endmodule

// File: src/cau_prep.sv
module cau_prep (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cau_pkg::t_sum  i_sum,
    output logic           o_valid,
    output cau_pkg::t_item o_item
);
    import cau_pkg::*;

    logic                r_v3, r_v4;
    logic [OP_BITS-1:0]  r_op3;
    logic                r_neg_r, r_neg_i;
    logic [SUM_BITS-1:0] r_mag_r, r_mag_i;
    logic [DEN_BITS-1:0] r_den3;
    t_item               n_item, r_item;

    function automatic t_lane make_lane(input logic [OP_BITS-1:0] op, input logic neg,
                                        input logic [SUM_BITS-1:0] mag,
                                        input logic [DEN_BITS-1:0] den);
        t_lane             l;
        logic [SUM_BITS:0] full;
        t_num              n;
        l    = '0;
        full = '0;
        n    = '0;
        l.neg = neg;
        case (t_op'(op))
            OP_ADD, OP_SUB, OP_NEG: full = {1'b0, mag};
            OP_MUL: full = ({1'b0, mag} + (SUM_BITS+1)'(ROUND_HALF)) >> FRAC_BITS;
            OP_DIV: begin
                if (den != '0) begin
                    // round(num * 2^F / den) = floor((num * 2^(F+1) + den) / (2 den))
                    n     = (t_num'(mag) << (FRAC_BITS + 1)) + t_num'(den);
                    l.div = 1'b1;
                    l.big = (n >> WORD_BITS) >= t_num'({den, 1'b0});
                    l.rem = DVS_BITS'(n >> WORD_BITS);
                    l.num = n[WORD_BITS-1:0];
                end
            end
            default: l.neg = 1'b0;
        endcase
        if (!l.div) begin
            l.big = |full[SUM_BITS:WORD_BITS];
            l.q   = full[WORD_BITS-1:0];
        end
        return l;
    endfunction

    always_comb begin
        n_item     = '0;
        n_item.re  = make_lane(r_op3, r_neg_r, r_mag_r, r_den3);
        n_item.im  = make_lane(r_op3, r_neg_i, r_mag_i, r_den3);
        n_item.dvs = {r_den3, 1'b0};
        n_item.dz  = (t_op'(r_op3) == OP_DIV) && (r_den3 == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_adv) begin
            r_v3 <= i_valid;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_op3   <= i_sum.op;
            r_den3  <= i_sum.den;
            r_neg_r <= i_sum.sr[SUM_BITS-1];
            r_neg_i <= i_sum.si[SUM_BITS-1];
            r_mag_r <= SUM_BITS'(i_sum.sr[SUM_BITS-1] ? -i_sum.sr : i_sum.sr);
            r_mag_i <= SUM_BITS'(i_sum.si[SUM_BITS-1] ? -i_sum.si : i_sum.si);
            r_item  <= n_item;
        end
    end

    assign o_valid = r_v4;
    assign o_item  = r_item;
endmodule

// File: src/cau_div_step.sv
module cau_div_step (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cau_pkg::t_item i_item,
    output logic           o_valid,
    output cau_pkg::t_item o_item
);
    import cau_pkg::*;

    logic  r_valid;
    t_item r_item, n_item;

    // one restoring step: bring down the next dividend bit, subtract if it fits
    function automatic t_lane step(input t_lane l, input logic [DVS_BITS-1:0] dvs);
        t_lane           s;
        logic [DVS_BITS:0] t;
        logic [DVS_BITS:0] d;
        logic            ge;
        s  = l;
        t  = {l.rem, l.num[WORD_BITS-1]};
        d  = {1'b0, dvs};
        ge = t >= d;
        if (l.div && !l.big) begin
            s.rem = ge ? DVS_BITS'(t - d) : DVS_BITS'(t);
            s.q   = {l.q[WORD_BITS-2:0], ge};
            s.num = {l.num[WORD_BITS-2:0], 1'b0};
        end
        return s;
    endfunction

    always_comb begin
        n_item    = i_item;
        n_item.re = step(i_item.re, i_item.dvs);
        n_item.im = step(i_item.im, i_item.dvs);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;
endmodule

// File: src/cau_sat.sv
module cau_sat (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_valid,
    input  cau_pkg::t_item i_item,
    output logic           o_valid,
    output cau_pkg::t_word o_real,
    output cau_pkg::t_word o_imag,
    output logic           o_dz,
    output logic           o_ov
);
    import cau_pkg::*;

    logic  r_valid, r_dz, r_ov;
    t_word r_real, r_imag, n_real, n_imag;
    logic  n_ov_r, n_ov_i;

    function automatic t_word clip(input t_lane l, output logic ov);
        t_word v;
        ov = 1'b0;
        if (!l.neg) begin
            if (l.big || (l.q > WORD_BITS'(WORD_MAX))) begin
                ov = 1'b1;
                v  = WORD_MAX;
            end else begin
                v = t_word'(l.q);
            end
        end else begin
            if (l.big || (l.q > WORD_BITS'(WORD_MIN))) begin
                ov = 1'b1;
                v  = WORD_MIN;
            end else begin
                v = t_word'(-l.q);
            end
        end
        return v;
    endfunction

    always_comb begin
        n_real = clip(i_item.re, n_ov_r);
        n_imag = clip(i_item.im, n_ov_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_real <= n_real;
            r_imag <= n_imag;
            r_dz   <= i_item.dz;
            r_ov   <= n_ov_r | n_ov_i;
        end
    end

    assign o_valid = r_valid;
    assign o_real  = r_real;
    assign o_imag  = r_imag;
    assign o_dz    = r_dz;
    assign o_ov    = r_ov;
endmodule

// File: src/complex_arithmetic_unit.sv
// Complex arithmetic unit on signed Q16.16 operands: add, subtract, multiply,
// divide and negate-a, one complex result per transfer with saturation and
// divide-by-zero flags. A new transfer is accepted in every cycle while the
// output is not stalled; each item passes from input to output through the
// front, which forms the six 32x32 products and their exact sums, the prep,
// which takes magnitudes and sets up rounding or the scaled dividend,
// the pipelined restoring divider (one quotient bit per stage, 66-bit
// subtract), and saturation into the output register. Every op travels
// through the divider stages so results leave in order. A stall on the output
// freezes the whole pipe; the input is ready whenever the output register is
// empty or being drained. Multiply and divide round to nearest, ties away from
// zero; a divide by zero returns zero with divide_by_zero set.
`include "complex_arithmetic_unit_defines.svh"

module complex_arithmetic_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cau_in_if.sink   i_cmd,
    cau_out_if.source o_res
);
    import cau_pkg::*;

    logic                 w_adv;
    logic                 w_sum_valid;
    t_sum                 w_sum;
    logic [WORD_BITS:0]   w_div_valid;
    t_item                w_div_item [WORD_BITS+1];
    logic                 w_res_zero;
    logic                 w_res_limit;

    // advance the whole pipe when the output register is free or being taken
    assign w_adv       = !o_res.valid || o_res.ready;
    assign i_cmd.ready = w_adv;

    // products and exact sums
    cau_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_valid  (i_cmd.valid),
        .i_op     (i_cmd.operation),
        .i_a_real (i_cmd.a_real),
        .i_a_imag (i_cmd.a_imag),
        .i_b_real (i_cmd.b_real),
        .i_b_imag (i_cmd.b_imag),
        .o_valid  (w_sum_valid),
        .o_sum    (w_sum)
    );

    // magnitudes, rounding and divider setup
    cau_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_sum_valid),
        .i_sum   (w_sum),
        .o_valid (w_div_valid[0]),
        .o_item  (w_div_item[0])
    );

    // one quotient bit per stage; non-divide items pass through unchanged
    for (genvar k = 0; k < WORD_BITS; k++) begin : g_div
        cau_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_div_valid[k]),
            .i_item  (w_div_item[k]),
            .o_valid (w_div_valid[k+1]),
            .o_item  (w_div_item[k+1])
        );
    end

    // saturate and hold the result for the output transfer
    cau_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (w_div_valid[WORD_BITS]),
        .i_item  (w_div_item[WORD_BITS]),
        .o_valid (o_res.valid),
        .o_real  (o_res.result_real),
        .o_imag  (o_res.result_imag),
        .o_dz    (o_res.divide_by_zero),
        .o_ov    (o_res.overflow)
    );

    // result shapes the checks below look for
    assign w_res_zero  = (o_res.result_real == '0) && (o_res.result_imag == '0)
                         && !o_res.overflow;
    assign w_res_limit = (o_res.result_real == WORD_MAX) || (o_res.result_real == WORD_MIN)
                         || (o_res.result_imag == WORD_MAX)
                         || (o_res.result_imag == WORD_MIN);

    `CAU_ASSERT_NOW(a_dz_zero, o_res.valid && o_res.divide_by_zero, w_res_zero)
    `CAU_ASSERT_NOW(a_stall_blocks_input, o_res.valid && !o_res.ready, !i_cmd.ready)
    `CAU_ASSERT_NOW(a_ov_at_limit, o_res.valid && o_res.overflow, w_res_limit)
    `CAU_ASSERT_NEXT(a_last_stage_moves, w_div_valid[WORD_BITS] && w_adv, o_res.valid)
endmodule

// File: tb/sv/cau_in_if.sv
`timescale 1ns / 100ps
// The channel interfaces cau_in_if and cau_out_if are shared with the block
// and come from the RTL folder.

// File: tb/sv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 100ps
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    // extra wait at the end, with slack beyond the block's pipeline depth
    localparam int DRAIN_CYCLES = WORD_BITS + 20;

    typedef struct {
        t_word re;
        t_word im;
        logic  dz;
        logic  ov;
    } t_cplx_res;

    logic i_clk;
    logic i_rst_n;

    cau_in_if  cmd_if ();
    cau_out_if res_if ();

    complex_arithmetic_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    t_cplx_res expected_q[$];
    int        fail_count = 0;
    bit        idle_on    = 1'b1;   // random gaps on both sides
    int        hold_off   = 0;      // cycles the receiver must still refuse

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Saturate a wide signed value into a word, flag overflow.
    function automatic t_word sat_word(input logic signed [199:0] v, inout logic ov);
        if (v > 200'sd2147483647) begin
            ov = 1'b1;
            return WORD_MAX;
        end
        if (v < -200'sd2147483648) begin
            ov = 1'b1;
            return WORD_MIN;
        end
        return t_word'(v[WORD_BITS-1:0]);
    endfunction

    // Round x / 2^FRAC_BITS to nearest, ties away from zero.
    function automatic logic signed [199:0] round_frac(input logic signed [199:0] x);
        logic signed [199:0] mag;
        mag = (x < 0) ? -x : x;
        mag = (mag + (200'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (x < 0) ? -mag : mag;
    endfunction

    // Round num * 2^FRAC_BITS / den (den > 0), ties away from zero.
    function automatic logic signed [199:0] round_quot(input logic signed [199:0] num,
                                                      input logic signed [199:0] den);
        logic signed [199:0] mag;
        mag = (num < 0) ? -num : num;
        mag = ((mag <<< (FRAC_BITS + 1)) + den) / (den <<< 1);
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic t_cplx_res complex_result(input logic [OP_BITS-1:0] op,
                                                 input t_word ar, input t_word ai,
                                                 input t_word br, input t_word bi);
        t_cplx_res r;
        logic signed [199:0] xr, xi, yr, yi, re, im, den;
        logic ov;
        xr = ar; xi = ai; yr = br; yi = bi;
        re = 0; im = 0; ov = 1'b0;
        r.dz = 1'b0;
        case (op)
            OP_ADD: begin
                re = xr + yr; im = xi + yi;
            end
            OP_SUB: begin
                re = xr - yr; im = xi - yi;
            end
            OP_MUL: begin
                re = round_frac(xr * yr - xi * yi);
                im = round_frac(xr * yi + xi * yr);
            end
            OP_DIV: begin
                den = yr * yr + yi * yi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = round_quot(xr * yr + xi * yi, den);
                    im = round_quot(xi * yr - xr * yi, den);
                end
            end
            OP_NEG: begin
                re = -xr; im = -xi;
            end
            default: ;
        endcase
        r.re = sat_word(re, ov);
        r.im = sat_word(im, ov);
        r.ov = ov;
        return r;
    endfunction

    // Offer one item and hold it until the transfer happens; valid stays up
    // so the next item can follow without a gap.
    task automatic send_item(input logic [OP_BITS-1:0] op, input t_word ar, input t_word ai,
                             input t_word br, input t_word bi);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            cmd_if.valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(negedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.operation <= op;
        cmd_if.a_real    <= ar;
        cmd_if.a_imag    <= ai;
        cmd_if.b_real    <= br;
        cmd_if.b_imag    <= bi;
        expected_q.push_back(complex_result(op, ar, ai, br, bi));
        do @(posedge i_clk); while (!cmd_if.ready);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        cmd_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return t_word'($urandom_range(0, 8) - 4);
            3: return t_word'($signed($urandom) >>> $urandom_range(8, 24));
            default: return t_word'($urandom);
        endcase
    endfunction

    // Receiver: random stalls, plus the long hold-off when asked.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off     <= hold_off - 1;
            res_if.ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            hold_off     <= $urandom_range(0, 9);
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Compare each transfer against the oldest expectation.
    always @(posedge i_clk) begin
        t_cplx_res e;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_q.size() == 0) begin
                $error("result with no expectation: re=%0d im=%0d",
                       res_if.result_real, res_if.result_imag);
                fail_count++;
            end else begin
                e = expected_q.pop_front();
                if (res_if.result_real !== e.re) begin
                    $error("result_real exp %0d got %0d", e.re, res_if.result_real);
                    fail_count++;
                end
                if (res_if.result_imag !== e.im) begin
                    $error("result_imag exp %0d got %0d", e.im, res_if.result_imag);
                    fail_count++;
                end
                if (res_if.divide_by_zero !== e.dz) begin
                    $error("divide_by_zero exp %0b got %0b", e.dz, res_if.divide_by_zero);
                    fail_count++;
                end
                if (res_if.overflow !== e.ov) begin
                    $error("overflow exp %0b got %0b", e.ov, res_if.overflow);
                    fail_count++;
                end
            end
        end
    end

    // Extremes, every operation and each special case.
    task automatic test_directed();
        send_item(OP_ADD, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN);
        send_item(OP_ADD, 32'sd65536, -32'sd5, 32'sd1, 32'sd5);
        send_item(OP_SUB, WORD_MIN, WORD_MAX, WORD_MAX, WORD_MIN);
        send_item(OP_SUB, 32'sd7, 32'sd0, 32'sd7, -32'sd1);
        send_item(OP_MUL, 32'sd98304, 32'sd65536, 32'sd65536, -32'sd98304);
        send_item(OP_MUL, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MAX);
        send_item(OP_MUL, 32'sd1, 32'sd0, 32'sd32768, 32'sd0);   // tie at one half
        send_item(OP_MUL, -32'sd1, 32'sd0, 32'sd32768, 32'sd0);  // negative tie
        send_item(OP_DIV, 32'sd65536, 32'sd65536, 32'sd0, 32'sd0);  // zero divisor
        send_item(OP_DIV, WORD_MAX, WORD_MIN, 32'sd0, 32'sd1);
        send_item(OP_DIV, 32'sd65536, 32'sd0, 32'sd131072, 32'sd0);
        send_item(OP_DIV, 32'sd1, -32'sd3, WORD_MIN, WORD_MAX);
        send_item(OP_DIV, 32'sd1, 32'sd0, 32'sd131072, 32'sd0);    // tie in quotient
        send_item(OP_NEG, WORD_MIN, WORD_MAX, 32'sd0, 32'sd0);      // most negative
        send_item(OP_NEG, 32'sd0, -32'sd1, WORD_MIN, 32'sd9);
        send_item(3'd5, WORD_MAX, 32'sd3, 32'sd4, 32'sd5);          // unused codes
        send_item(3'd6, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        send_item(3'd7, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    endtask

    // Random items, mostly the defined operations.
    task automatic test_random(input int count);
        logic [OP_BITS-1:0] op;
        for (int n = 0; n < count; n++) begin
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_item(op, rand_word(), rand_word(), rand_word(), rand_word());
        end
    endtask

    // Stall the receiver for a long stretch while the sender keeps offering.
    task automatic test_backpressure();
        cmd_if.valid <= 1'b0;
        @(posedge i_clk);
        hold_off <= 200;
        @(negedge i_clk);
        test_random(80);
        wait_drained();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        cmd_if.valid     = 1'b0;
        cmd_if.operation = '0;
        cmd_if.a_real    = '0;
        cmd_if.a_imag    = '0;
        cmd_if.b_real    = '0;
        cmd_if.b_imag    = '0;
        res_if.ready     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        wait_drained();   // sender pauses until everything has come back
        test_random(400);
        test_backpressure();
        idle_on = 1'b0;   // final stretch at full rate
        test_random(250);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("tb_complex_arithmetic_unit: PASS");
        end else begin
            $display("tb_complex_arithmetic_unit: FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_complex_arithmetic_unit: FAIL");
        $finish;
    end

endmodule
